/* design/tpf_pkg.sv */
// Shared types, constants and helpers for the two-pole frame audio filter.
// No dependencies; every other design file imports this package.

package tpf_pkg;

  localparam int FRAME_LEN  = 8;   // samples per frame, one lane each
  localparam int SMP_W      = 16;  // sample and coefficient width
  localparam int ACC_W      = 32;  // wrapping accumulator width
  localparam int FRAC_BITS  = 14;  // fixed-point fraction bits
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COEF_PER_W = CFG_DATA_W / SMP_W;  // coefficients per packed register

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam smp_t SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam smp_t SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN    = 3'd0,
    REG_P1_LO   = 3'd1,
    REG_P1_HI   = 3'd2,
    REG_P2_LO   = 3'd3,
    REG_P2_HI   = 3'd4
  } cfg_reg_t;

  // Load strobes for the four register levels of each lane.
  typedef struct packed {
    logic en_mul;
    logic en_pair;
    logic en_quad;
    logic en_sum;
  } lane_ctl_t;

  // Hand-over of one frame from the lanes to the merge stage.
  typedef struct packed {
    logic load;
    logic restart;
    logic last;
  } mrg_ctl_t;

  // Arithmetic shift right by the fraction bits, saturate to a sample.
  function automatic smp_t sat_shift(input acc_t a);
    acc_t                          full;
    logic signed [ACC_W-FRAC_BITS-1:0] sh;
    full = a >>> FRAC_BITS;
    sh   = full[ACC_W-FRAC_BITS-1:0];
    if (&sh[ACC_W-FRAC_BITS-1:SMP_W-1] || ~|sh[ACC_W-FRAC_BITS-1:SMP_W-1]) begin
      sat_shift = smp_t'(sh[SMP_W-1:0]);
    end else if (sh[ACC_W-FRAC_BITS-1]) begin
      sat_shift = SMP_MIN;
    end else begin
      sat_shift = SMP_MAX;
    end
  endfunction

endpackage

/* design/tpf_lane.sv */
// One filter lane: the feed-forward part of one output sample.
// Eight products, then a registered adder tree. Depends on tpf_pkg.

module tpf_lane import tpf_pkg::*; (
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  smp_t      coef [FRAME_LEN],
  input  smp_t      smp  [FRAME_LEN],
  output acc_t      sum
);

  acc_t prod_r [FRAME_LEN];
  acc_t pair_r [FRAME_LEN/2];
  acc_t quad_r [FRAME_LEN/4];
  acc_t sum_r;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      for (int j = 0; j < FRAME_LEN; j++) begin
        prod_r[j] <= coef[j] * smp[j];
      end
    end
    if (ctl.en_pair) begin
      for (int j = 0; j < FRAME_LEN/2; j++) begin
        pair_r[j] <= prod_r[2*j] + prod_r[2*j+1];
      end
    end
    if (ctl.en_quad) begin
      for (int j = 0; j < FRAME_LEN/4; j++) begin
        quad_r[j] <= pair_r[2*j] + pair_r[2*j+1];
      end
    end
    if (ctl.en_sum) begin
      sum_r <= quad_r[0] + quad_r[1];
    end
  end

  assign sum = sum_r;

endmodule

/* design/tpf_merge.sv */
// Merge stage: adds the history feedback to each lane's sum, saturates,
// holds the output beat and keeps the two history samples. Depends on tpf_pkg.

module tpf_merge import tpf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mrg_ctl_t               ctl,
  input  acc_t                   fir [FRAME_LEN],
  input  smp_t                   p1  [FRAME_LEN],
  input  smp_t                   p2  [FRAME_LEN],
  output logic                   free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [FRAME_LEN*SMP_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic f1_v_r, f1_v_nxt;
  logic f2_v_r, f2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic f2_move;

  acc_t fir1_r [FRAME_LEN];
  acc_t hm1_r  [FRAME_LEN];
  acc_t hm2_r  [FRAME_LEN];
  acc_t acc_r  [FRAME_LEN];
  smp_t out_smp_r [FRAME_LEN];
  logic last1_r, last2_r, out_last_r;
  smp_t hist1_r, hist2_r;
  smp_t h1_use, h2_use;

  // Take a frame only when the previous one has written the history.
  assign free    = !f1_v_r && !f2_v_r;
  assign f2_move = f2_v_r && (!out_v_r || out_tready);
  assign h1_use  = ctl.restart ? '0 : hist1_r;
  assign h2_use  = ctl.restart ? '0 : hist2_r;

  always_comb begin
    f1_v_nxt  = ctl.load;
    f2_v_nxt  = f1_v_r || (f2_v_r && !f2_move);
    out_v_nxt = f2_move || (out_v_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r  <= 1'b0;
      f2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      hist1_r <= '0;
      hist2_r <= '0;
    end else begin
      f1_v_r  <= f1_v_nxt;
      f2_v_r  <= f2_v_nxt;
      out_v_r <= out_v_nxt;
      if (f2_move) begin
        hist1_r <= sat_shift(acc_r[FRAME_LEN-2]);
        hist2_r <= sat_shift(acc_r[FRAME_LEN-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      last1_r <= ctl.last;
      for (int i = 0; i < FRAME_LEN; i++) begin
        fir1_r[i] <= fir[i];
        hm1_r[i]  <= p1[i] * h1_use;
        hm2_r[i]  <= p2[i] * h2_use;
      end
    end
    if (f1_v_r) begin
      last2_r <= last1_r;
      for (int i = 0; i < FRAME_LEN; i++) begin
        acc_r[i] <= fir1_r[i] + hm1_r[i] + hm2_r[i];
      end
    end
    if (f2_move) begin
      out_last_r <= last2_r;
      for (int i = 0; i < FRAME_LEN; i++) begin
        out_smp_r[i] <= sat_shift(acc_r[i]);
      end
    end
  end

  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_pack
    assign out_tdata[i*SMP_W +: SMP_W] = out_smp_r[i];
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;

endmodule

/* design/two_pole_frame_audio_filter.sv */
// Top level of the two-pole frame audio filter: configuration registers,
// input stage, eight lanes (tpf_lane) and the merge stage (tpf_merge). Uses tpf_pkg.
//
//   port group | dir | fields (lowest bit first)
//   -----------+-----+--------------------------------------------------------
//   in_*       | in  | tdata: sample_0..sample_7; tuser: restart; tlast: end_of_buffer
//   out_*      | out | tdata: out_0..out_7; tlast: last
//   cfg_*      | in  | addr 0 gain, 1/2 pole one low/high, 3/4 pole two low/high
//
// The input register and the lanes' register levels form a five-level pipeline that
// takes a beat every cycle until it fills; the merge stage's history loop (multiply,
// add, saturate, history register) takes a new frame only after the previous frame
// has written the history, which sets the sustained rate.
// Reset (rst_n low, synchronous) clears valids, history and configuration registers.
// A stalled output beat holds in the output register while the pipeline keeps
// accepting beats until it is full.

module two_pole_frame_audio_filter import tpf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [FRAME_LEN*SMP_W-1:0] in_tdata,   // sample_0 .. sample_7
  input  logic                       in_tuser,   // restart
  input  logic                       in_tlast,   // end_of_buffer
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [FRAME_LEN*SMP_W-1:0] out_tdata,  // out_0 .. out_7
  output logic                       out_tlast,  // last
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_addr,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int STG = 5;  // input register plus four lane levels

  // Configuration registers
  smp_t                  gain_r;
  logic [CFG_DATA_W-1:0] p1_lo_r, p1_hi_r, p2_lo_r, p2_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      p1_lo_r <= '0;
      p1_hi_r <= '0;
      p2_lo_r <= '0;
      p2_hi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN:  gain_r  <= smp_t'(cfg_wdata[SMP_W-1:0]);
        REG_P1_LO: p1_lo_r <= cfg_wdata;
        REG_P1_HI: p1_hi_r <= cfg_wdata;
        REG_P2_LO: p2_lo_r <= cfg_wdata;
        REG_P2_HI: p2_hi_r <= cfg_wdata;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Unpack the pole coefficients.
  smp_t p1_c [FRAME_LEN];
  smp_t p2_c [FRAME_LEN];

  for (genvar j = 0; j < FRAME_LEN; j++) begin : g_coef
    if (j < COEF_PER_W) begin : g_lo
      assign p1_c[j] = smp_t'(p1_lo_r[j*SMP_W +: SMP_W]);
      assign p2_c[j] = smp_t'(p2_lo_r[j*SMP_W +: SMP_W]);
    end else begin : g_hi
      assign p1_c[j] = smp_t'(p1_hi_r[(j-COEF_PER_W)*SMP_W +: SMP_W]);
      assign p2_c[j] = smp_t'(p2_hi_r[(j-COEF_PER_W)*SMP_W +: SMP_W]);
    end
  end

  // Gain-scaled second-pole taps; they are registered from the configuration registers
  // and settle before any beat that arrives after a write reaches the multipliers.
  acc_t g2_prod [FRAME_LEN];
  smp_t g2_r    [FRAME_LEN];

  always_comb begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      g2_prod[k] = p2_c[k] * gain_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      g2_r[k] <= sat_shift(g2_prod[k]);
    end
  end

  // Pipeline control: a stage loads when it is empty or its content moves on.
  logic [STG-1:0] stg_v_r, stg_v_nxt;
  logic [STG-1:0] stg_rst_r, stg_last_r;
  logic [STG-1:0] rdy, ld, mv;
  logic           mrg_free;
  mrg_ctl_t       mrg_ctl;
  lane_ctl_t      lane_ctl;

  always_comb begin
    rdy[STG-1] = !stg_v_r[STG-1] || mrg_free;
    for (int k = STG-2; k >= 0; k--) begin
      rdy[k] = !stg_v_r[k] || rdy[k+1];
    end
    ld[0] = in_tvalid && rdy[0];
    for (int k = 1; k < STG; k++) begin
      ld[k] = stg_v_r[k-1] && rdy[k];
    end
    for (int k = 0; k < STG-1; k++) begin
      mv[k] = ld[k+1];
    end
    mv[STG-1] = stg_v_r[STG-1] && mrg_free;
    for (int k = 0; k < STG; k++) begin
      stg_v_nxt[k] = ld[k] || (stg_v_r[k] && !mv[k]);
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  // Carry the frame flags alongside the lane data.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      stg_rst_r[0]  <= in_tuser;
      stg_last_r[0] <= in_tlast;
    end
    for (int k = 1; k < STG; k++) begin
      if (ld[k]) begin
        stg_rst_r[k]  <= stg_rst_r[k-1];
        stg_last_r[k] <= stg_last_r[k-1];
      end
    end
  end

  // Input register for the samples.
  smp_t smp0_r [FRAME_LEN];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        smp0_r[i] <= smp_t'(in_tdata[i*SMP_W +: SMP_W]);
      end
    end
  end

  assign lane_ctl.en_mul  = ld[1];
  assign lane_ctl.en_pair = ld[2];
  assign lane_ctl.en_quad = ld[3];
  assign lane_ctl.en_sum  = ld[4];

  // Lanes: lane i sums gain*s[i] and g2[k]*s[i-1-k] over k < i.
  acc_t fir [FRAME_LEN];

  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_lane
    smp_t coef [FRAME_LEN];
    smp_t tap  [FRAME_LEN];

    always_comb begin
      coef[0] = gain_r;
      tap[0]  = smp0_r[i];
      for (int j = 1; j < FRAME_LEN; j++) begin
        if (j <= i) begin
          coef[j] = g2_r[j-1];
          tap[j]  = smp0_r[i-j];
        end else begin
          coef[j] = '0;
          tap[j]  = '0;
        end
      end
    end

    tpf_lane u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .coef (coef),
      .smp  (tap),
      .sum  (fir[i])
    );
  end

  assign mrg_ctl.load    = mv[STG-1];
  assign mrg_ctl.restart = stg_rst_r[STG-1];
  assign mrg_ctl.last    = stg_last_r[STG-1];

  tpf_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mrg_ctl),
    .fir        (fir),
    .p1         (p1_c),
    .p2         (p2_c),
    .free       (mrg_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
